FILE: design/ffba_pkg.sv
// Shared constants, status codes and entry type for the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SZ_W = 17;
  localparam logic [SZ_W-1:0] POOL_BYTES = 17'd65536;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  typedef struct packed {
    logic [SZ_W-1:0] start;
    logic [SZ_W-1:0] length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage

FILE: design/ffba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: table sequencer around the entry RAM.
// The sequencer moves one table entry per cycle through the entry RAM ports.
// The scan and the shift together walk the table once, and the statistics pass walks it again.
// Throughput: one request at a time; a new request is taken once the result is registered.
// Reset clears the entry count, the output valid and sets pool_size to 65536.
`timescale 1ns / 1ps
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [16:0] request_size,
  input  logic [15:0] block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [16:0] granted_offset,
  output logic [6:0]  live_count,
  output logic [16:0] used_bytes,
  output logic [16:0] max_gap,
  output logic [6:0]  gap_count
);
  localparam int IW = ffba_pkg::IDX_W;
  localparam int CW = ffba_pkg::CNT_W;
  localparam int SW = ffba_pkg::SZ_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_TAIL, S_INS_START, S_INS, S_PUT,
    S_REM_START, S_REM, S_STAT0, S_STAT, S_FINISH
  } state_t;

  state_t state;
  logic [CW-1:0] cnt;
  logic [SW-1:0] pool_size;
  logic cmd;
  logic [SW-1:0] size;
  logic [15:0] target;
  logic [SW:0] pos;
  logic [IW-1:0] cidx;
  logic [IW-1:0] sk;
  logic [IW-1:0] hit;
  logic [1:0] res_status;
  logic [SW-1:0] res_granted;
  logic [SW-1:0] used_acc;
  logic [SW-1:0] largest_acc;
  logic [CW-1:0] frag_acc;

  logic ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  ffba_pkg::entry_t ram_wdata;
  ffba_pkg::entry_t ram_rdata;
  logic [ffba_pkg::ENTRY_W-1:0] rdata_raw;

  ffba_ram #(.WIDTH(ffba_pkg::ENTRY_W), .DEPTH(ffba_pkg::MAX_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata_raw)
  );
  assign ram_rdata = ffba_pkg::entry_t'(rdata_raw);

  logic [SW:0] e_start;
  logic [SW:0] e_end;
  logic [SW:0] gap;
  logic [SW:0] tail;
  logic last;
  logic [CW-1:0] cnt_m1;
  logic tail_fits;

  always_comb begin
    e_start = {1'b0, ram_rdata.start};
    e_end = e_start + {1'b0, ram_rdata.length};
    gap = (e_start > pos) ? e_start - pos : '0;
    cnt_m1 = cnt - CW'(1);
    last = ({1'b0, cidx} == cnt_m1);
    tail = ({1'b0, pool_size} > pos) ? {1'b0, pool_size} - pos : '0;
    tail_fits = (pos <= {1'b0, pool_size}) && (tail >= {1'b0, size});
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = sk;
    ram_wdata = ram_rdata;
    ram_raddr = cidx + IW'(1);
    case (state)
      S_IDLE: ram_raddr = '0;
      S_INS_START: ram_raddr = cnt_m1[IW-1:0];
      S_INS: begin
        ram_we = 1'b1;
        ram_waddr = sk + IW'(1);
        ram_raddr = sk - IW'(1);
      end
      S_PUT: begin
        ram_we = 1'b1;
        ram_waddr = hit;
        ram_wdata.start = pos[SW-1:0];
        ram_wdata.length = size;
      end
      S_REM_START: ram_raddr = hit + IW'(1);
      S_REM: begin
        ram_we = 1'b1;
        ram_waddr = sk - IW'(1);
        ram_raddr = sk + IW'(1);
      end
      S_STAT0: ram_raddr = '0;
      default: ram_raddr = cidx + IW'(1);
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pool_size <= ffba_pkg::POOL_BYTES;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        pool_size <= (cfg_data > ffba_pkg::POOL_BYTES) ? ffba_pkg::POOL_BYTES : cfg_data;
      end
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= command;
            size <= request_size;
            target <= block_offset;
            pos <= '0;
            cidx <= '0;
            res_status <= ffba_pkg::ST_OK;
            res_granted <= '0;
            if (command == ffba_pkg::CMD_ALLOC && cnt >= CW'(ffba_pkg::MAX_ENTRIES)) begin
              res_status <= ffba_pkg::ST_FULL;
              state <= S_STAT0;
            end else if (cnt == '0) begin
              if (command == ffba_pkg::CMD_ALLOC) begin
                state <= S_TAIL;
              end else begin
                res_status <= ffba_pkg::ST_NOTFOUND;
                state <= S_STAT0;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmd == ffba_pkg::CMD_ALLOC) begin
            if (gap >= {1'b0, size}) begin
              hit <= cidx;
              state <= S_INS_START;
            end else begin
              pos <= e_end;
              if (last) begin
                state <= S_TAIL;
              end else begin
                cidx <= cidx + IW'(1);
              end
            end
          end else begin
            if (ram_rdata.start == {1'b0, target}) begin
              hit <= cidx;
              state <= S_REM_START;
            end else if (last) begin
              res_status <= ffba_pkg::ST_NOTFOUND;
              state <= S_STAT0;
            end else begin
              cidx <= cidx + IW'(1);
            end
          end
        end
        S_TAIL: begin
          if (tail_fits) begin
            hit <= cnt[IW-1:0];
            state <= S_PUT;
          end else begin
            res_status <= ffba_pkg::ST_NOSPACE;
            state <= S_STAT0;
          end
        end
        S_INS_START: begin
          sk <= cnt_m1[IW-1:0];
          state <= S_INS;
        end
        S_INS: begin
          if (sk == hit) begin
            state <= S_PUT;
          end else begin
            sk <= sk - IW'(1);
          end
        end
        S_PUT: begin
          cnt <= cnt + CW'(1);
          res_granted <= pos[SW-1:0];
          state <= S_STAT0;
        end
        S_REM_START: begin
          if ({1'b0, hit} == cnt_m1) begin
            cnt <= cnt_m1;
            state <= S_STAT0;
          end else begin
            sk <= hit + IW'(1);
            state <= S_REM;
          end
        end
        S_REM: begin
          if ({1'b0, sk} == cnt_m1) begin
            cnt <= cnt_m1;
            state <= S_STAT0;
          end else begin
            sk <= sk + IW'(1);
          end
        end
        S_STAT0: begin
          pos <= '0;
          cidx <= '0;
          used_acc <= '0;
          largest_acc <= '0;
          frag_acc <= '0;
          state <= (cnt == '0) ? S_FINISH : S_STAT;
        end
        S_STAT: begin
          if (gap != '0) begin
            frag_acc <= frag_acc + CW'(1);
            if (gap[SW-1:0] > largest_acc) begin
              largest_acc <= gap[SW-1:0];
            end
          end
          used_acc <= used_acc + ram_rdata.length;
          pos <= e_end;
          if (last) begin
            state <= S_FINISH;
          end else begin
            cidx <= cidx + IW'(1);
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status <= res_status;
            granted_offset <= res_granted;
            live_count <= cnt;
            used_bytes <= used_acc;
            max_gap <= (tail[SW-1:0] > largest_acc) ? tail[SW-1:0] : largest_acc;
            gap_count <= (tail != '0) ? frag_acc + CW'(1) : frag_acc;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(ffba_pkg::MAX_ENTRIES))
    else $error("entry count exceeds table depth");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted_offset != '0) |-> status == ffba_pkg::ST_OK)
    else $error("nonzero grant without ok status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ffba_pkg::ST_FULL) |-> live_count == CW'(ffba_pkg::MAX_ENTRIES))
    else $error("table full reported with free entries");
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the first-fit block allocator with a behavioral predictor.
`timescale 1ns / 1ps
module testbench;
  typedef struct packed {
    logic        command;
    logic [16:0] request_size;
    logic [15:0] block_offset;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] granted_offset;
    logic [6:0]  live_count;
    logic [16:0] used_bytes;
    logic [16:0] max_gap;
    logic [6:0]  gap_count;
  } outcome_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [16:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic command = 0;
  logic [16:0] request_size = 0;
  logic [15:0] block_offset = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [16:0] granted_offset;
  logic [6:0] live_count;
  logic [16:0] used_bytes;
  logic [16:0] max_gap;
  logic [6:0] gap_count;

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .request_size(request_size), .block_offset(block_offset),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .granted_offset(granted_offset), .live_count(live_count),
    .used_bytes(used_bytes), .max_gap(max_gap),
    .gap_count(gap_count)
  );

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  logic accepted_in = 0;

  longint pool_bytes = 65536;
  longint tbl_start[ffba_pkg::MAX_ENTRIES];
  longint tbl_len[ffba_pkg::MAX_ENTRIES];
  int tbl_live = 0;

  initial forever #5 clk = ~clk;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (at %0t)", what, got, want, $time);
    mismatches++;
  endtask

  function automatic outcome_t allocate_or_free(input request_t rq);
    outcome_t o;
    longint pos, gap, used, largest, frags, tail;
    int i, k;
    bit fits;
    o = '0;
    o.status = ffba_pkg::ST_OK;
    if (rq.command == ffba_pkg::CMD_ALLOC) begin
      if (tbl_live >= ffba_pkg::MAX_ENTRIES) begin
        o.status = ffba_pkg::ST_FULL;
      end else begin
        pos = 0;
        fits = 0;
        for (i = 0; i < tbl_live; i++) begin
          gap = tbl_start[i] > pos ? tbl_start[i] - pos : 0;
          if (gap >= longint'(rq.request_size)) begin
            fits = 1;
            break;
          end
          pos = tbl_start[i] + tbl_len[i];
        end
        if (!fits) fits = pos <= pool_bytes && pool_bytes - pos >= longint'(rq.request_size);
        if (!fits) begin
          o.status = ffba_pkg::ST_NOSPACE;
        end else begin
          for (k = tbl_live; k > i; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_len[k] = tbl_len[k-1];
          end
          tbl_start[i] = pos;
          tbl_len[i] = longint'(rq.request_size);
          tbl_live++;
          o.granted_offset = 17'(pos);
        end
      end
    end else begin
      fits = 0;
      for (i = 0; i < tbl_live; i++) begin
        if (tbl_start[i] == longint'(rq.block_offset)) begin
          fits = 1;
          break;
        end
      end
      if (!fits) begin
        o.status = ffba_pkg::ST_NOTFOUND;
      end else begin
        for (k = i; k + 1 < tbl_live; k++) begin
          tbl_start[k] = tbl_start[k+1];
          tbl_len[k] = tbl_len[k+1];
        end
        tbl_live--;
      end
    end
    used = 0; largest = 0; frags = 0; pos = 0;
    for (i = 0; i < tbl_live; i++) begin
      gap = tbl_start[i] > pos ? tbl_start[i] - pos : 0;
      if (gap > 0) begin
        frags++;
        if (gap > largest) largest = gap;
      end
      used += tbl_len[i];
      pos = tbl_start[i] + tbl_len[i];
    end
    tail = pool_bytes > pos ? pool_bytes - pos : 0;
    if (tail > 0) begin
      frags++;
      if (tail > largest) largest = tail;
    end
    o.live_count = 7'(tbl_live);
    o.used_bytes = 17'(used);
    o.max_gap = 17'(largest);
    o.gap_count = 7'(frags);
    return o;
  endfunction

  // Driver: bursts of transfers with random gaps.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_in) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (pending_requests.size() > 0) begin
          request_t rq;
          rq = pending_requests.pop_front();
          in_valid <= 1;
          command <= rq.command;
          request_size <= rq.request_size;
          block_offset <= rq.block_offset;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
          end
        end else begin
          in_valid <= 0;
        end
      end
      stall_phase++;
      case ((stall_phase / 64) % 4)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (stall_phase % 7) < 3;
      endcase
    end
  end

  // Monitor: predict at input transfer, check at output transfer.
  always @(posedge clk) begin
    accepted_in <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        request_t rq;
        rq.command = command;
        rq.request_size = request_size;
        rq.block_offset = block_offset;
        expected_outcomes.push_back(allocate_or_free(rq));
        idle_cycles <= 0;
      end else if (out_valid && !out_stall) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          outcome_t e;
          e = expected_outcomes.pop_front();
          if (status !== e.status) report("status", status, e.status);
          if (granted_offset !== e.granted_offset)
            report("granted_offset", granted_offset, e.granted_offset);
          if (live_count !== e.live_count) report("live_count", live_count, e.live_count);
          if (used_bytes !== e.used_bytes) report("used_bytes", used_bytes, e.used_bytes);
          if (max_gap !== e.max_gap)
            report("max_gap", max_gap, e.max_gap);
          if (gap_count !== e.gap_count)
            report("gap_count", gap_count, e.gap_count);
        end
      end
    end
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic push(input logic cmd, input int sz, input int off);
    request_t rq;
    rq.command = cmd;
    rq.request_size = 17'(sz);
    rq.block_offset = 16'(off);
    pending_requests.push_back(rq);
  endtask

  task automatic drain;
    while (pending_requests.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_pool(input logic [16:0] v);
    @(negedge clk);
    cfg_write <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 0;
    pool_bytes = (v > 17'd65536) ? 65536 : longint'(v);
  endtask

  function automatic int live_offset;
    if (tbl_live == 0 || $urandom_range(0, 5) == 0) return int'($urandom_range(0, 65535));
    return int'(tbl_start[$urandom_range(0, tbl_live - 1)] & 16'hffff);
  endfunction

  // Keep one item in flight so frees can target live starts from the predictor.
  task automatic drain_one;
    while (pending_requests.size() > 0) @(posedge clk);
  endtask

  function automatic int rand_live_offset;
    return live_offset();
  endfunction

  task automatic random_phase(input int n, input int max_sz);
    int i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: push(ffba_pkg::CMD_ALLOC, $urandom_range(0, 131071), $urandom_range(0, 65535));
        1: push(ffba_pkg::CMD_ALLOC, 0, $urandom_range(0, 65535));
        2, 3, 4: push(ffba_pkg::CMD_ALLOC, $urandom_range(0, max_sz),
                      $urandom_range(0, 65535));
        5: push(ffba_pkg::CMD_FREE, $urandom_range(0, 131071), $urandom_range(0, 65535));
        default: push(ffba_pkg::CMD_FREE, $urandom_range(0, 131071), rand_live_offset());
      endcase
      drain_one();
    end
  endtask

  initial begin
    int i;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Directed part.
    push(ffba_pkg::CMD_ALLOC, 0, 0);
    push(ffba_pkg::CMD_ALLOC, 0, 16'hffff);
    push(ffba_pkg::CMD_ALLOC, 100, 0);
    push(ffba_pkg::CMD_ALLOC, 65536, 0);
    push(ffba_pkg::CMD_ALLOC, 131071, 0);
    push(ffba_pkg::CMD_FREE, 0, 0);
    push(ffba_pkg::CMD_FREE, 131071, 0);
    push(ffba_pkg::CMD_FREE, 0, 16'hffff);
    push(ffba_pkg::CMD_ALLOC, 65436, 0);
    push(ffba_pkg::CMD_ALLOC, 1, 0);
    push(ffba_pkg::CMD_FREE, 0, 100);
    push(ffba_pkg::CMD_ALLOC, 10, 0);
    push(ffba_pkg::CMD_FREE, 0, 0);
    push(ffba_pkg::CMD_FREE, 0, 100);
    drain();
    // Fill the table to full with small blocks.
    for (i = 0; i < 66; i++) push(ffba_pkg::CMD_ALLOC, $urandom_range(0, 3), 0);
    drain();
    for (i = 0; i < 64; i++) push(ffba_pkg::CMD_FREE, 0, rand_live_offset());
    drain();
    set_pool(17'd20);
    push(ffba_pkg::CMD_ALLOC, 20, 0);
    push(ffba_pkg::CMD_ALLOC, 0, 0);
    push(ffba_pkg::CMD_ALLOC, 1, 0);
    drain();
    set_pool(17'd0);
    push(ffba_pkg::CMD_ALLOC, 0, 0);
    push(ffba_pkg::CMD_ALLOC, 1, 0);
    drain();
    set_pool(17'h1ffff);
    random_phase(150, 4000);
    drain();
    set_pool(17'($urandom_range(16, 2000)));
    random_phase(150, 300);
    drain();
    set_pool(17'd65536);
    random_phase(150, 1500);
    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: first_fit_block_allocator.f
design/ffba_pkg.sv
design/ffba_ram.sv
design/first_fit_block_allocator.sv
tb/sv/testbench.sv
